@@ src/pdp_pkg.sv @@
package pdp_pkg;

   // Field widths
   localparam int CMD_W      = 2;
   localparam int PIX_W      = 8;
   localparam int CIDX_W     = 10;
   localparam int KIND_W     = 2;
   localparam int POS_W      = 10;
   localparam int CNT_W      = 11;
   localparam int QCNT_W     = 21;
   localparam int QSUM_W     = QCNT_W + 2;
   localparam int CFG_W      = 11;
   localparam int CSR_IDX_W  = 2;

   // Default frame limits
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;

   // Counter limits and the active-pixel mask
   localparam logic [CNT_W-1:0]  CNT11_MAX = '1;
   localparam logic [QCNT_W-1:0] CNT21_MAX = '1;
   localparam logic [PIX_W-1:0]  PIX_MASK  = 8'hF0;

   // Register values after reset
   localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
   localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;
   localparam logic [CFG_W-1:0] RST_CENTER_X     = 11'd320;
   localparam logic [CFG_W-1:0] RST_CENTER_Y     = 11'd240;

   // Quadrant slots: {bottom, right}
   localparam logic [1:0] QUAD_TL = 2'd0;
   localparam logic [1:0] QUAD_TR = 2'd1;
   localparam logic [1:0] QUAD_BL = 2'd2;
   localparam logic [1:0] QUAD_BR = 2'd3;

   typedef enum logic [CMD_W-1:0] {
      CMD_PIXEL       = 2'd0,
      CMD_READ_COLUMN = 2'd1,
      CMD_READ_QUAD   = 2'd2,
      CMD_START_FRAME = 2'd3
   } pdp_cmd_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ROW    = 2'd0,
      KIND_COLUMN = 2'd1,
      KIND_QUAD   = 2'd2
   } pdp_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FRAME_WIDTH  = 2'd0,
      CSR_FRAME_HEIGHT = 2'd1,
      CSR_CENTER_X     = 2'd2,
      CSR_CENTER_Y     = 2'd3
   } pdp_csr_type;

   // Control of one item in the column-store stage
   typedef struct packed {
      logic         emit;      // item gives a result
      pdp_kind_type kind;
      logic         wr;        // pixel inside the frame: write the column back
      logic         active;    // pixel counts
      logic         hit;       // column entry written since frame start
      logic         in_range;  // column read inside the width
   } pdp_ctl_type;

   typedef struct packed {
      logic [QCNT_W-1:0] top_left;
      logic [QCNT_W-1:0] top_right;
      logic [QCNT_W-1:0] bottom_left;
      logic [QCNT_W-1:0] bottom_right;
      logic [QCNT_W-1:0] total;
   } pdp_quad_type;

   function automatic logic [CNT_W-1:0] sat_inc11(input logic [CNT_W-1:0] v);
      return (v == CNT11_MAX) ? v : v + CNT_W'(1);
   endfunction

   function automatic logic [QCNT_W-1:0] sat_inc21(input logic [QCNT_W-1:0] v);
      return (v == CNT21_MAX) ? v : v + QCNT_W'(1);
   endfunction

endpackage

@@ src/pdp_req_if.sv @@
interface pdp_req_if import pdp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [PIX_W-1:0]  pixel;
   logic [CIDX_W-1:0] column_index;

   modport source (output valid, command, pixel, column_index, input ready);
   modport sink   (input valid, command, pixel, column_index, output ready);
endinterface

@@ src/pdp_rsp_if.sv @@
interface pdp_rsp_if import pdp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] result_kind;
   logic [POS_W-1:0]  position;
   logic [CNT_W-1:0]  count;
   logic [QCNT_W-1:0] top_left;
   logic [QCNT_W-1:0] top_right;
   logic [QCNT_W-1:0] bottom_left;
   logic [QCNT_W-1:0] bottom_right;
   logic [QCNT_W-1:0] total;

   modport source (output valid, result_kind, position, count, top_left, top_right,
                   bottom_left, bottom_right, total, input ready);
   modport sink   (input valid, result_kind, position, count, top_left, top_right,
                   bottom_left, bottom_right, total, output ready);
endinterface

@@ src/pixel_density_projection_core.sv @@
// Path: item into the stage register, then its result into the output register.
// Throughput: one item per cycle unless the output holds a result; the column store
// read-modify-write keeps up (one read port, one write port, last write forwarded).
// Reset: synchronous, restores the frame registers and clears all counts and positions;
// the column store needs no clearing pass, items are taken from the first cycle after.
module pixel_density_projection_core import pdp_pkg::*; #(
   parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   pdp_req_if.sink              req,
   pdp_rsp_if.source            rsp,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);

   logic             accept;
   logic             s1_valid_ff, s1_valid_in;
   logic             s1_adv;
   logic             out_valid_ff, out_valid_in;

   logic [CW-1:0]    rd_addr;
   logic [CNT_W-1:0] rd_data;
   logic             wr_en;
   logic [CW-1:0]    wr_addr;
   logic [CNT_W-1:0] wr_data;

   pdp_ctl_type      s1_ctl;
   logic [CW-1:0]    s1_addr;
   logic [POS_W-1:0] s1_position;
   logic [CNT_W-1:0] s1_row_count;
   pdp_quad_type     s1_quad;
   logic [CNT_W-1:0] col_count;

   pdp_kind_type     out_kind_ff;
   logic [POS_W-1:0] out_position_ff;
   logic [CNT_W-1:0] out_count_ff;
   pdp_quad_type     out_quad_ff;

   // Handshake: the stage advances unless its result finds the output held
   assign s1_adv     = s1_valid_ff && (!s1_ctl.emit || !out_valid_ff || rsp.ready);
   assign req.ready  = !s1_valid_ff || s1_adv;
   assign accept     = req.valid && req.ready;

   pdp_frame_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_frame_ctrl (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_index    (pdp_csr_type'(csr_index)),
      .csr_wdata    (csr_wdata),
      .accept       (accept),
      .command      (pdp_cmd_type'(req.command)),
      .pixel        (req.pixel),
      .column_index (req.column_index),
      .rd_addr      (rd_addr),
      .s1_ctl       (s1_ctl),
      .s1_addr      (s1_addr),
      .s1_position  (s1_position),
      .s1_row_count (s1_row_count),
      .s1_quad      (s1_quad)
   );

   pdp_col_mem #(
      .DEPTH (MAX_WIDTH)
   ) u_col_mem (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   pdp_col_update #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_col_update (
      .clock     (clock),
      .reset     (reset),
      .advance   (s1_adv),
      .ctl       (s1_ctl),
      .addr      (s1_addr),
      .rd_data   (rd_data),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .col_count (col_count)
   );

   // Stage and output occupancy
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (s1_adv && s1_ctl.emit) begin
         out_valid_in = 1'b1;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (s1_adv && s1_ctl.emit) begin
         out_kind_ff     <= s1_ctl.kind;
         out_position_ff <= s1_position;
         out_count_ff    <= (s1_ctl.kind == KIND_COLUMN) ? col_count : s1_row_count;
         out_quad_ff     <= s1_quad;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.result_kind  = out_kind_ff;
   assign rsp.position     = out_position_ff;
   assign rsp.count        = out_count_ff;
   assign rsp.top_left     = out_quad_ff.top_left;
   assign rsp.top_right    = out_quad_ff.top_right;
   assign rsp.bottom_left  = out_quad_ff.bottom_left;
   assign rsp.bottom_right = out_quad_ff.bottom_right;
   assign rsp.total        = out_quad_ff.total;

`ifndef NO_ASSERTIONS
   // A result blocked at the output must stop further input transfers
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_ctl.emit && out_valid_ff && !rsp.ready |-> !req.ready)
      else $error("input taken while a result is blocked");

   // A row cannot hold more active pixels than the widest frame
   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.result_kind == KIND_ROW) |-> 32'(rsp.count) <= MAX_WIDTH)
      else $error("row count beyond the frame width");

   // A column cannot hold more active pixels than the tallest frame
   a_column_bound: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.result_kind == KIND_COLUMN) |-> 32'(rsp.count) <= MAX_HEIGHT)
      else $error("column count beyond the frame height");

   // Row and column results carry no quadrant figures
   a_quad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp.result_kind != KIND_QUAD) |-> rsp.total == '0 && rsp.top_left == '0)
      else $error("quadrant figures on a row or column result");
`endif

endmodule

@@ src/pdp_col_mem.sv @@
module pdp_col_mem import pdp_pkg::*; #(
   parameter int  DEPTH = DEF_MAX_WIDTH,
   localparam int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [CNT_W-1:0] rd_data,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [CNT_W-1:0] wr_data
);

   logic [CNT_W-1:0] mem [DEPTH];
   logic [CNT_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/pdp_frame_ctrl.sv @@
module pdp_frame_ctrl import pdp_pkg::*; #(
   parameter int  MAX_WIDTH  = DEF_MAX_WIDTH,
   parameter int  MAX_HEIGHT = DEF_MAX_HEIGHT,
   localparam int CW         = $clog2(MAX_WIDTH),
   localparam int WW         = $clog2(MAX_WIDTH + 1),
   localparam int RW         = $clog2(MAX_HEIGHT + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  pdp_csr_type       csr_index,
   input  logic [CFG_W-1:0]  csr_wdata,
   input  logic              accept,
   input  pdp_cmd_type       command,
   input  logic [PIX_W-1:0]  pixel,
   input  logic [CIDX_W-1:0] column_index,
   output logic [CW-1:0]     rd_addr,
   output pdp_ctl_type       s1_ctl,
   output logic [CW-1:0]     s1_addr,
   output logic [POS_W-1:0]  s1_position,
   output logic [CNT_W-1:0]  s1_row_count,
   output pdp_quad_type      s1_quad
);

   // Registers
   logic [CFG_W-1:0]  frame_width_ff, frame_height_ff, center_x_ff, center_y_ff;
   logic [CW-1:0]     col_pos_ff, col_pos_in;
   logic [RW-1:0]     row_pos_ff, row_pos_in;
   logic [CNT_W-1:0]  row_cnt_ff, row_cnt_in;
   logic [QCNT_W-1:0] quad_ff [4];
   logic [QCNT_W-1:0] quad_in [4];
   logic [WW-1:0]     hw_ff, hw_in;      // columns written since frame start

   pdp_ctl_type       ctl_ff, ctl_in;
   logic [CW-1:0]     addr_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [CNT_W-1:0]  rcnt_ff, rcnt_in;
   pdp_quad_type      qout_ff, qout_in;

   logic [WW-1:0]     eff_w;
   logic [RW-1:0]     eff_h;
   logic              in_frame, active, row_end, col_hit;
   logic [1:0]        quad_sel;
   logic [CNT_W-1:0]  row_cnt_act;
   logic [QSUM_W-1:0] quad_sum;

   // Clamp the frame size to the supported range
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_w = WW'(1);
      end else if (32'(frame_width_ff) > MAX_WIDTH) begin
         eff_w = WW'(MAX_WIDTH);
      end else begin
         eff_w = WW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         eff_h = RW'(1);
      end else if (32'(frame_height_ff) > MAX_HEIGHT) begin
         eff_h = RW'(MAX_HEIGHT);
      end else begin
         eff_h = RW'(frame_height_ff);
      end
   end

   // Pixel classification
   assign in_frame    = (32'(row_pos_ff) < 32'(eff_h)) && (32'(col_pos_ff) < 32'(eff_w));
   assign active      = |(pixel & PIX_MASK);
   assign row_end     = (32'(col_pos_ff) + 32'd1) >= 32'(eff_w);
   assign col_hit     = 32'(col_pos_ff) < 32'(hw_ff);
   assign quad_sel    = {32'(row_pos_ff) >= 32'(center_y_ff),
                         32'(col_pos_ff) >= 32'(center_x_ff)};
   assign row_cnt_act = active ? sat_inc11(row_cnt_ff) : row_cnt_ff;

   // Quadrant total, wide enough not to overflow; saturated when read out
   assign quad_sum = QSUM_W'(quad_ff[QUAD_TL]) + QSUM_W'(quad_ff[QUAD_TR])
                   + QSUM_W'(quad_ff[QUAD_BL]) + QSUM_W'(quad_ff[QUAD_BR]);

   // Column store address
   assign rd_addr = (command == CMD_READ_COLUMN) ? CW'(column_index) : col_pos_ff;

   // Next frame state and stage payload
   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      row_cnt_in = row_cnt_ff;
      quad_in    = quad_ff;
      hw_in      = hw_ff;
      ctl_in     = '0;
      pos_in     = '0;
      rcnt_in    = '0;
      qout_in    = '0;
      if (accept) begin
         unique case (command)
            CMD_PIXEL: begin
               if (in_frame) begin
                  ctl_in.wr     = 1'b1;
                  ctl_in.active = active;
                  ctl_in.hit    = col_hit;
                  if (active) begin
                     quad_in[quad_sel] = sat_inc21(quad_ff[quad_sel]);
                  end
                  if (!col_hit) begin
                     hw_in = WW'(32'(col_pos_ff) + 32'd1);
                  end
                  if (row_end) begin
                     ctl_in.emit = 1'b1;
                     ctl_in.kind = KIND_ROW;
                     pos_in      = POS_W'(row_pos_ff);
                     rcnt_in     = row_cnt_act;
                     row_cnt_in  = '0;
                     col_pos_in  = '0;
                     row_pos_in  = row_pos_ff + RW'(1);
                  end else begin
                     col_pos_in = col_pos_ff + CW'(1);
                     row_cnt_in = row_cnt_act;
                  end
               end
            end
            CMD_READ_COLUMN: begin
               ctl_in.emit     = 1'b1;
               ctl_in.kind     = KIND_COLUMN;
               ctl_in.in_range = 32'(column_index) < 32'(eff_w);
               ctl_in.hit      = ctl_in.in_range && (32'(column_index) < 32'(hw_ff));
               pos_in          = POS_W'(column_index);
            end
            CMD_READ_QUAD: begin
               ctl_in.emit          = 1'b1;
               ctl_in.kind          = KIND_QUAD;
               qout_in.top_left     = quad_ff[QUAD_TL];
               qout_in.top_right    = quad_ff[QUAD_TR];
               qout_in.bottom_left  = quad_ff[QUAD_BL];
               qout_in.bottom_right = quad_ff[QUAD_BR];
               qout_in.total        = (quad_sum > QSUM_W'(CNT21_MAX)) ?
                                      CNT21_MAX : QCNT_W'(quad_sum);
            end
            CMD_START_FRAME: begin
               col_pos_in = '0;
               row_pos_in = '0;
               row_cnt_in = '0;
               quad_in    = '{default: '0};
               hw_in      = '0;
            end
         endcase
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= RST_FRAME_WIDTH;
         frame_height_ff <= RST_FRAME_HEIGHT;
         center_x_ff     <= RST_CENTER_X;
         center_y_ff     <= RST_CENTER_Y;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_wdata;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_wdata;
            CSR_CENTER_X:     center_x_ff     <= csr_wdata;
            CSR_CENTER_Y:     center_y_ff     <= csr_wdata;
         endcase
      end
   end

   // Frame state
   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         row_cnt_ff <= '0;
         quad_ff    <= '{default: '0};
         hw_ff      <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         row_cnt_ff <= row_cnt_in;
         quad_ff    <= quad_in;
         hw_ff      <= hw_in;
      end
   end

   // Stage payload, loaded on each input transfer
   always_ff @(posedge clock) begin
      if (accept) begin
         ctl_ff  <= ctl_in;
         addr_ff <= rd_addr;
         pos_ff  <= pos_in;
         rcnt_ff <= rcnt_in;
         qout_ff <= qout_in;
      end
   end

   assign s1_ctl       = ctl_ff;
   assign s1_addr      = addr_ff;
   assign s1_position  = pos_ff;
   assign s1_row_count = rcnt_ff;
   assign s1_quad      = qout_ff;

endmodule

@@ src/pdp_col_update.sv @@
module pdp_col_update import pdp_pkg::*; #(
   parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
   localparam int CW        = $clog2(MAX_WIDTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  pdp_ctl_type      ctl,
   input  logic [CW-1:0]    addr,
   input  logic [CNT_W-1:0] rd_data,
   output logic             wr_en,
   output logic [CW-1:0]    wr_addr,
   output logic [CNT_W-1:0] wr_data,
   output logic [CNT_W-1:0] col_count
);

   logic             fwd_valid_ff;
   logic [CW-1:0]    fwd_addr_ff;
   logic [CNT_W-1:0] fwd_data_ff;
   logic [CNT_W-1:0] old_count;
   logic [CNT_W-1:0] new_count;

   // Old count: forward the last write, treat unwritten entries as zero
   always_comb begin
      if (!ctl.hit) begin
         old_count = '0;
      end else if (fwd_valid_ff && (fwd_addr_ff == addr)) begin
         old_count = fwd_data_ff;
      end else begin
         old_count = rd_data;
      end
   end

   assign new_count = ctl.active ? sat_inc11(old_count) : old_count;

   // Write back as the item leaves the stage
   assign wr_en     = advance && ctl.wr;
   assign wr_addr   = addr;
   assign wr_data   = new_count;
   assign col_count = ctl.in_range ? old_count : '0;

   // Hold the latest write for the item read in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (wr_en) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         fwd_addr_ff <= addr;
         fwd_data_ff <= new_count;
      end
   end

endmodule

@@ dv/testbench.sv @@
module testbench;
   import pdp_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 80;

   typedef struct packed {
      pdp_cmd_type       command;
      logic [PIX_W-1:0]  pixel;
      logic [CIDX_W-1:0] column_index;
   } pdp_item_type;

   typedef struct packed {
      pdp_kind_type     kind;
      logic [POS_W-1:0] position;
      logic [CNT_W-1:0] count;
      pdp_quad_type     quad;
   } pdp_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // Channel and register-port drive
   logic              drv_valid = 1'b0;
   logic [CMD_W-1:0]  drv_command = '0;
   logic [PIX_W-1:0]  drv_pixel = '0;
   logic [CIDX_W-1:0] drv_column_index = '0;
   logic              rsp_ready = 1'b0;
   logic              csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0]  csr_wdata = '0;

   pdp_req_if req_if ();
   pdp_rsp_if rsp_if ();

   assign req_if.valid        = drv_valid;
   assign req_if.command      = drv_command;
   assign req_if.pixel        = drv_pixel;
   assign req_if.column_index = drv_column_index;
   assign rsp_if.ready        = rsp_ready;

   pixel_density_projection_core uut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Stimulus and expectation stores
   pdp_item_type   req_stream[$];
   pdp_result_type results_due[$];
   pdp_item_type   cur_item;
   int          queued_items = 0;
   int          mismatches = 0;
   int          cycle_count = 0;
   int          send_idle_pct = 0;
   int          stall_pct = 0;
   logic        hold_req = 1'b0;
   logic        hold_done = 1'b0;
   int          hold_left = 0;

   // Predictor state: frame registers and the projection counters
   logic [CFG_W-1:0]  frame_cfg [4] = '{RST_FRAME_WIDTH, RST_FRAME_HEIGHT,
                                        RST_CENTER_X, RST_CENTER_Y};
   logic [CNT_W-1:0]  column_hist [DEF_MAX_WIDTH];
   logic [QCNT_W-1:0] quad_hist [4];
   logic [CNT_W-1:0]  row_count;
   int                col_pos;
   int                row_pos;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic int eff_dim(input logic [CFG_W-1:0] v, input int limit);
      if (v == '0) return 1;
      if (int'(v) > limit) return limit;
      return int'(v);
   endfunction

   function automatic void clear_projection();
      foreach (column_hist[i]) column_hist[i] = '0;
      foreach (quad_hist[i]) quad_hist[i] = '0;
      row_count = '0;
      col_pos = 0;
      row_pos = 0;
   endfunction

   // Work out the result of one accepted item and advance the counters
   function automatic void project_item(input pdp_item_type it);
      int                w;
      int                h;
      logic [1:0]        quad_sel;
      logic [QSUM_W-1:0] sum;
      pdp_result_type    r;
      w = eff_dim(frame_cfg[CSR_FRAME_WIDTH], DEF_MAX_WIDTH);
      h = eff_dim(frame_cfg[CSR_FRAME_HEIGHT], DEF_MAX_HEIGHT);
      r = '0;
      case (it.command)
         CMD_START_FRAME: begin
            clear_projection();
         end
         CMD_READ_COLUMN: begin
            r.kind = KIND_COLUMN;
            r.position = it.column_index;
            if (int'(it.column_index) < w) r.count = column_hist[it.column_index];
            results_due.push_back(r);
         end
         CMD_READ_QUAD: begin
            sum = '0;
            foreach (quad_hist[i]) sum = sum + QSUM_W'(quad_hist[i]);
            r.kind = KIND_QUAD;
            r.quad.top_left     = quad_hist[QUAD_TL];
            r.quad.top_right    = quad_hist[QUAD_TR];
            r.quad.bottom_left  = quad_hist[QUAD_BL];
            r.quad.bottom_right = quad_hist[QUAD_BR];
            r.quad.total = (sum > QSUM_W'(CNT21_MAX)) ? CNT21_MAX : sum[QCNT_W-1:0];
            results_due.push_back(r);
         end
         default: begin
            // drop pixels once the frame is complete
            if (row_pos < h && col_pos < w) begin
               if ((it.pixel & PIX_MASK) != '0) begin
                  // slot layout is {bottom, right}
                  quad_sel = {row_pos >= int'(frame_cfg[CSR_CENTER_Y]),
                              col_pos >= int'(frame_cfg[CSR_CENTER_X])};
                  if (column_hist[col_pos] != '1) column_hist[col_pos] += CNT_W'(1);
                  if (quad_hist[quad_sel] != '1) quad_hist[quad_sel] += QCNT_W'(1);
                  if (row_count != '1) row_count += CNT_W'(1);
               end
               if (col_pos + 1 >= w) begin
                  r.kind = KIND_ROW;
                  r.position = POS_W'(row_pos);
                  r.count = row_count;
                  results_due.push_back(r);
                  row_count = '0;
                  col_pos = 0;
                  row_pos++;
               end else begin
                  col_pos++;
               end
            end
         end
      endcase
   endfunction

   // Driver: predict each transfer, then offer the next queued item or idle
   always @(posedge clock) begin
      if (reset) begin
         drv_valid <= 1'b0;
      end else begin
         if (drv_valid && req_if.ready) project_item(cur_item);
         if (!drv_valid || req_if.ready) begin
            if (req_stream.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               cur_item = req_stream.pop_front();
               drv_valid <= 1'b1;
               drv_command <= cur_item.command;
               drv_pixel <= cur_item.pixel;
               drv_column_index <= cur_item.column_index;
            end else begin
               drv_valid <= 1'b0;
            end
         end
      end
   end

   function automatic void compare_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
   endfunction

   // Monitor: check each result transfer, then decide the next ready
   always @(posedge clock) begin
      pdp_result_type want;
      if (!reset) begin
         if (rsp_if.valid && rsp_ready) begin
            if (results_due.size() == 0) begin
               mismatches++;
               $display("%0t: result with none expected, actual kind %0d position %0d count %0d",
                        $time, rsp_if.result_kind, rsp_if.position, rsp_if.count);
            end else begin
               want = results_due.pop_front();
               compare_field("result_kind", 32'(want.kind), 32'(rsp_if.result_kind));
               compare_field("position", 32'(want.position), 32'(rsp_if.position));
               compare_field("count", 32'(want.count), 32'(rsp_if.count));
               compare_field("top_left", 32'(want.quad.top_left), 32'(rsp_if.top_left));
               compare_field("top_right", 32'(want.quad.top_right), 32'(rsp_if.top_right));
               compare_field("bottom_left", 32'(want.quad.bottom_left),
                             32'(rsp_if.bottom_left));
               compare_field("bottom_right", 32'(want.quad.bottom_right),
                             32'(rsp_if.bottom_right));
               compare_field("total", 32'(want.quad.total), 32'(rsp_if.total));
            end
         end
         // hold off once for a long stretch when asked, else stall at random
         if (hold_req && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   // Timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic push_item(input pdp_cmd_type cmd, input logic [PIX_W-1:0] pix,
                            input logic [CIDX_W-1:0] idx);
      pdp_item_type it;
      it.command = cmd;
      it.pixel = pix;
      it.column_index = idx;
      req_stream.push_back(it);
      queued_items++;
   endtask

   function automatic logic [PIX_W-1:0] rand_pixel();
      if ($urandom_range(0, 1) == 1) return {4'($urandom_range(1, 15)), 4'($urandom)};
      return {4'h0, 4'($urandom)};
   endfunction

   // Queue a read, mostly inside the width; now and then a stray frame start
   task automatic push_read(input int w);
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         if ($urandom_range(0, 9) < 7)
            push_item(CMD_READ_COLUMN, 8'($urandom), CIDX_W'($urandom_range(0, w - 1)));
         else
            push_item(CMD_READ_COLUMN, 8'($urandom), CIDX_W'($urandom));
      end else if (pick < 95) begin
         push_item(CMD_READ_QUAD, 8'($urandom), CIDX_W'($urandom));
      end else begin
         push_item(CMD_START_FRAME, 8'($urandom), CIDX_W'($urandom));
      end
   endtask

   // Queue one frame of pixels with reads mixed in, a tail of extra pixels and reads
   task automatic gen_frame(input int n_pix, input int read_pct, input bit fresh,
                            input int tail);
      int w;
      w = eff_dim(frame_cfg[CSR_FRAME_WIDTH], DEF_MAX_WIDTH);
      if (fresh) push_item(CMD_START_FRAME, 8'($urandom), CIDX_W'($urandom));
      for (int k = 0; k < n_pix; k++) begin
         push_item(CMD_PIXEL, rand_pixel(), CIDX_W'($urandom));
         if ($urandom_range(0, 99) < read_pct) push_read(w);
      end
      for (int k = 0; k < tail; k++) push_item(CMD_PIXEL, rand_pixel(), CIDX_W'($urandom));
      queued_items -= tail;
      push_item(CMD_READ_QUAD, 8'($urandom), CIDX_W'($urandom));
      push_read(w);
      push_read(w);
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (req_stream.size() != 0 || drv_valid || results_due.size() != 0);
   endtask

   task automatic write_reg(input pdp_csr_type idx, input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      frame_cfg[idx] = value;
   endtask

   // Drain, let in-flight pixels settle, rewrite every register, pick the idling
   task automatic start_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                              input logic [CFG_W-1:0] cx, input logic [CFG_W-1:0] cy,
                              input int mode);
      wait_drained();
      repeat (4) @(posedge clock);
      write_reg(CSR_FRAME_WIDTH, w);
      write_reg(CSR_FRAME_HEIGHT, h);
      write_reg(CSR_CENTER_X, cx);
      write_reg(CSR_CENTER_Y, cy);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      case (mode)
         1:       begin send_idle_pct = 65; stall_pct = 0;  end
         2:       begin send_idle_pct = 0;  stall_pct = 65; end
         3:       begin send_idle_pct = 16; stall_pct = 16; end
         default: begin send_idle_pct = 0;  stall_pct = 0;  end
      endcase
   endtask

   initial begin
      int                base;
      int                phase;
      int                pick;
      int                n_pix;
      logic [CFG_W-1:0]  w;
      logic [CFG_W-1:0]  h;
      logic [CFG_W-1:0]  cx;
      logic [CFG_W-1:0]  cy;

      clear_projection();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset registers: empty reads, then mask edges on the first row
      push_item(CMD_READ_QUAD, 8'hFF, 10'h3FF);
      push_item(CMD_READ_COLUMN, 8'h00, 10'd0);
      push_item(CMD_READ_COLUMN, 8'h00, 10'd1023);
      push_item(CMD_START_FRAME, 8'h00, 10'd0);
      push_item(CMD_PIXEL, 8'h00, 10'd0);
      push_item(CMD_PIXEL, 8'h0F, 10'h3FF);
      push_item(CMD_PIXEL, 8'h10, 10'd0);
      push_item(CMD_PIXEL, 8'hFF, 10'd0);
      push_item(CMD_PIXEL, 8'h80, 10'd0);
      push_item(CMD_READ_COLUMN, 8'h00, 10'd2);
      push_item(CMD_READ_QUAD, 8'h00, 10'd0);

      // Zero width and height act as one; centre beyond both; pixel after the frame
      start_phase(11'd0, 11'd0, 11'h7FF, 11'h7FF, 0);
      push_item(CMD_START_FRAME, 8'h00, 10'd0);
      push_item(CMD_PIXEL, 8'hF0, 10'd0);
      push_item(CMD_PIXEL, 8'hFF, 10'd0);
      push_item(CMD_READ_COLUMN, 8'h00, 10'd0);
      push_item(CMD_READ_COLUMN, 8'h00, 10'd1);
      push_item(CMD_READ_QUAD, 8'h00, 10'd0);

      // Small frame touching all four quadrants
      start_phase(11'd3, 11'd2, 11'd1, 11'd1, 0);
      push_item(CMD_START_FRAME, 8'h00, 10'd0);
      push_item(CMD_PIXEL, 8'hF0, 10'd0);
      push_item(CMD_PIXEL, 8'h00, 10'd0);
      push_item(CMD_PIXEL, 8'h1F, 10'd0);
      push_item(CMD_PIXEL, 8'h20, 10'd0);
      push_item(CMD_PIXEL, 8'hFF, 10'd0);
      push_item(CMD_PIXEL, 8'h8F, 10'd0);
      push_item(CMD_READ_QUAD, 8'h00, 10'd0);
      push_item(CMD_READ_COLUMN, 8'h00, 10'd2);

      // Width above the maximum: the start of one wide row, reads across it
      start_phase(11'h7FF, 11'd1, 11'd1024, 11'd0, 2);
      gen_frame(48, 10, 1'b1, 3);

      // Height above the maximum: one pixel per row across the centre row
      start_phase(11'd1, 11'h7FF, 11'd0, 11'd20, 1);
      gen_frame(48, 10, 1'b1, 3);

      // Largest legal registers on a partial frame
      start_phase(11'd1024, 11'd1024, 11'd1023, 11'd1024, 3);
      gen_frame(40, 10, 1'b1, 0);

      // Long receiver hold-off while pixels keep coming
      start_phase(11'd2, 11'd16, 11'd1, 11'd8, 0);
      hold_req = 1'b1;
      gen_frame(32, 10, 1'b1, 2);

      // Random small frames under all idling patterns
      phase = 0;
      base = queued_items;
      while (queued_items - base < 780) begin
         pick = $urandom_range(0, 9);
         w = CFG_W'($urandom_range(1, 12));
         h = CFG_W'($urandom_range(1, 8));
         if (pick == 0) w = '0;
         if (pick == 1) h = '0;
         if (pick == 2) w = CFG_W'($urandom_range(13, 64));
         cx = CFG_W'($urandom_range(0, int'(w) + 2));
         cy = CFG_W'($urandom_range(0, int'(h) + 2));
         if (pick == 3) cx = '1;
         if (pick == 4) cy = '1;
         if (pick == 5) begin
            cx = w;
            cy = h;
         end
         start_phase(w, h, cx, cy, phase % 4);
         repeat ($urandom_range(1, 4)) begin
            n_pix = eff_dim(w, DEF_MAX_WIDTH) * eff_dim(h, DEF_MAX_HEIGHT);
            if ($urandom_range(0, 5) == 0) n_pix = $urandom_range(0, n_pix);
            gen_frame(n_pix, 15, $urandom_range(0, 5) != 0, $urandom_range(0, 3));
         end
         // noise: any command with any content
         repeat ($urandom_range(0, 6))
            push_item(pdp_cmd_type'($urandom_range(0, 3)), 8'($urandom), CIDX_W'($urandom));
         phase++;
      end

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ filelist.f @@
src/pdp_pkg.sv
src/pdp_req_if.sv
src/pdp_rsp_if.sv
src/pdp_col_mem.sv
src/pdp_frame_ctrl.sv
src/pdp_col_update.sv
src/pixel_density_projection_core.sv
dv/testbench.sv
